// File: rtl/fcfpt_pkg.sv
// ----------------------------------------------------------------------------
// fcfpt_pkg
// shared types and constants of the five-channel fixed-point tween unit
// ----------------------------------------------------------------------------
package fcfpt_pkg;

    // channel order inside the unit: x, y, angle, pitch, dist
    localparam int CH_COUNT  = 5;
    localparam int CH_X      = 0;
    localparam int CH_Y      = 1;
    localparam int CH_ANGLE  = 2;
    localparam int CH_PITCH  = 3;
    localparam int CH_DIST   = 4;

    localparam int DATA_W    = 16;              // width of one channel value
    localparam int DIFF_W    = DATA_W + 1;      // full-width target minus start
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = DATA_W + FRAC_BITS;
    localparam int START_AW  = 12;              // width of the angle fields
    localparam int CNT_W16   = 16;              // width of the tick count

    localparam logic [FRAC_BITS-1:0] HALF_ONE = 16'h8000;

    // request kind carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // one quotient bit per cycle over the whole 16.16 quotient
    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int IN_W  = 4 * 2 * DATA_W + 2 * START_AW + CNT_W16;
    localparam int OUT_W = CH_COUNT * DATA_W + CNT_W16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } fcfpt_state_t;

    // sequencer to divider lanes
    typedef struct packed {
        logic load;
        logic shift;
    } fcfpt_lane_ctrl_t;

endpackage

// File: rtl/fcfpt_div_lane.sv
// ----------------------------------------------------------------------------
// fcfpt_div_lane
// bit-serial signed divider lane: (diff << 16) / n, truncated toward zero
// ----------------------------------------------------------------------------
module fcfpt_div_lane (
    input  logic                                  aclk,
    input  fcfpt_pkg::fcfpt_lane_ctrl_t           ctrl,
    input  logic signed [fcfpt_pkg::DIFF_W-1:0]   diff,
    input  logic        [fcfpt_pkg::DATA_W-1:0]   divisor,
    output logic        [fcfpt_pkg::ACC_W-1:0]    step
);

    logic                            neg_reg,  neg_next;
    logic [fcfpt_pkg::DATA_W-1:0]    num_reg,  num_next;
    logic [fcfpt_pkg::DATA_W-1:0]    rem_reg,  rem_next;
    logic [fcfpt_pkg::ACC_W-1:0]     quo_reg,  quo_next;

    logic [fcfpt_pkg::DIFF_W-1:0]    mag;
    logic [fcfpt_pkg::DIFF_W-1:0]    rem_sh;
    logic [fcfpt_pkg::DIFF_W-1:0]    rem_sub;
    logic                            fits;

    // magnitude always fits 16 bits: |diff| <= 65535
    assign mag     = diff[fcfpt_pkg::DIFF_W-1] ? (-diff) : diff;
    assign rem_sh  = {rem_reg, num_reg[fcfpt_pkg::DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign fits    = (rem_sh >= {1'b0, divisor});

    always_comb begin
        neg_next = neg_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        priority if (ctrl.load) begin
            neg_next = diff[fcfpt_pkg::DIFF_W-1];
            num_next = mag[fcfpt_pkg::DATA_W-1:0];
            rem_next = '0;
            quo_next = '0;
        end else if (ctrl.shift) begin
            // dividend bits enter msb first, zeros follow for the fraction
            num_next = {num_reg[fcfpt_pkg::DATA_W-2:0], 1'b0};
            rem_next = fits ? rem_sub[fcfpt_pkg::DATA_W-1:0]
                            : rem_sh[fcfpt_pkg::DATA_W-1:0];
            quo_next = {quo_reg[fcfpt_pkg::ACC_W-2:0], fits};
        end else begin
            // hold the finished quotient
            quo_next = quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // sign restored on the magnitude quotient, wraps to 32 bits
    assign step = neg_reg ? (~quo_reg + {{(fcfpt_pkg::ACC_W-1){1'b0}}, 1'b1}) : quo_reg;

endmodule

// File: rtl/five_channel_fixed_point_tween_unit.sv
// ----------------------------------------------------------------------------
// five_channel_fixed_point_tween_unit: 16.16 tween of x, y, angle, pitch, dist
// tick request: accumulators advance on accept and the result is registered from emit
// start request: divide (32 quotient bits in the bit-serial divider lanes), fix, emit;
// either way the next request is taken only once the unit is back in idle
// a result held downstream keeps the next one in emit and holds off requests
// synchronous active-low reset clears accumulators, steps, count and handshake
// ----------------------------------------------------------------------------
module five_channel_fixed_point_tween_unit #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x, start_y, start_angle(12), start_pitch, start_dist,
    // target_x, target_y, target_angle(12), target_pitch, target_dist, step_total
    input  logic [fcfpt_pkg::IN_W-1:0]     s_axis_tdata,
    // cmd: 0 start, 1 tick
    input  logic                           s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x, out_y, out_angle, out_pitch, out_dist, ticks_left
    output logic [fcfpt_pkg::OUT_W-1:0]    m_axis_tdata,
    // done_res
    output logic                           m_axis_tlast
);

    localparam int DW  = fcfpt_pkg::DATA_W;
    localparam int XW  = fcfpt_pkg::DIFF_W;
    localparam int AW  = fcfpt_pkg::START_AW;
    localparam int CW  = fcfpt_pkg::DIV_CNT_W;
    localparam int NCH = fcfpt_pkg::CH_COUNT;
    // msb index of an accumulator, top of its upper half
    localparam int AH  = fcfpt_pkg::ACC_W - 1;
    localparam int FB  = fcfpt_pkg::FRAC_BITS;
    // full turn minus one, at the width of the differences
    localparam logic [XW-1:0] TURN_M1 = XW'((1 << ANGLE_BITS) - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(fcfpt_pkg::DIV_STEPS - 1);

    // input field extraction, lowest bits first
    logic signed [DW-1:0] sx, sy, sp, sd, tx, ty, tp, td;
    logic        [AW-1:0] sa, ta;
    logic        [DW-1:0] n_in;

    assign sx   = s_axis_tdata[15:0];
    assign sy   = s_axis_tdata[31:16];
    assign sa   = s_axis_tdata[43:32];
    assign sp   = s_axis_tdata[59:44];
    assign sd   = s_axis_tdata[75:60];
    assign tx   = s_axis_tdata[91:76];
    assign ty   = s_axis_tdata[107:92];
    assign ta   = s_axis_tdata[119:108];
    assign tp   = s_axis_tdata[135:120];
    assign td   = s_axis_tdata[151:136];
    assign n_in = s_axis_tdata[167:152];

    // state
    fcfpt_pkg::fcfpt_state_t          state_reg, state_next;
    logic [CW-1:0]                    cnt_reg,   cnt_next;
    logic [fcfpt_pkg::ACC_W-1:0]      acc_reg [NCH];
    logic [fcfpt_pkg::ACC_W-1:0]      acc_next[NCH];
    logic [fcfpt_pkg::ACC_W-1:0]      inc_reg [NCH];
    logic [fcfpt_pkg::ACC_W-1:0]      inc_next[NCH];
    logic [DW-1:0]                    rem_reg,   rem_next;
    logic [DW-1:0]                    div_reg,   div_next;
    logic                             done_reg,  done_next;
    logic                             mvalid_reg, mvalid_next;
    logic [fcfpt_pkg::OUT_W-1:0]      mdata_reg,  mdata_next;
    logic                             mlast_reg,  mlast_next;

    logic                             in_acc;
    logic                             out_free;
    fcfpt_pkg::fcfpt_lane_ctrl_t      lane_ctrl;

    // start-side arithmetic
    logic [DW-1:0]          n_eff;
    logic [XW-1:0]          adiff;
    logic [XW-1:0]          turn_u;
    logic signed [XW-1:0]   diff [NCH];
    logic [fcfpt_pkg::ACC_W-1:0] lane_step[NCH];
    logic [DW-1:0]          start_val[NCH];

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !mvalid_reg || m_axis_tready;

    // zero ticks run as one tick
    assign n_eff = (n_in == '0) ? {{(DW-1){1'b0}}, 1'b1} : n_in;

    // angle difference masked to the angle width, wrapped negative by a full turn minus one
    assign adiff  = XW'(ta) - XW'(sa);
    assign turn_u = XW'(adiff[ANGLE_BITS-1:0]);

    assign diff[fcfpt_pkg::CH_X]     = {tx[DW-1], tx} - {sx[DW-1], sx};
    assign diff[fcfpt_pkg::CH_Y]     = {ty[DW-1], ty} - {sy[DW-1], sy};
    assign diff[fcfpt_pkg::CH_ANGLE] = adiff[ANGLE_BITS-1] ? (turn_u - TURN_M1) : turn_u;
    assign diff[fcfpt_pkg::CH_PITCH] = {tp[DW-1], tp} - {sp[DW-1], sp};
    assign diff[fcfpt_pkg::CH_DIST]  = {td[DW-1], td} - {sd[DW-1], sd};

    assign start_val[fcfpt_pkg::CH_X]     = sx;
    assign start_val[fcfpt_pkg::CH_Y]     = sy;
    assign start_val[fcfpt_pkg::CH_ANGLE] = DW'(sa);
    assign start_val[fcfpt_pkg::CH_PITCH] = sp;
    assign start_val[fcfpt_pkg::CH_DIST]  = sd;

    // one divider lane per channel, all sharing the tick count as divisor
    for (genvar g = 0; g < NCH; g++) begin : g_lane
        fcfpt_div_lane u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .diff    (diff[g]),
            .divisor (div_reg),
            .step    (lane_step[g])
        );
    end

    // sequencer: idle -> divide (32 quotient bits) -> fix step -> emit, ticks go idle -> emit
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        done_next   = done_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        for (int i = 0; i < NCH; i++) begin
            acc_next[i] = acc_reg[i];
            inc_next[i] = inc_reg[i];
        end
        lane_ctrl       = '0;
        s_axis_tready   = 1'b0;

        // result taken downstream
        if (mvalid_reg && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            fcfpt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    if (s_axis_tuser == fcfpt_pkg::CMD_TICK) begin
                        // tick request: advance all channels, count down
                        for (int i = 0; i < NCH; i++) begin
                            acc_next[i] = acc_reg[i] + inc_reg[i];
                        end
                        if (rem_reg != '0) begin
                            rem_next  = rem_reg - {{(DW-1){1'b0}}, 1'b1};
                            done_next = (rem_reg == {{(DW-1){1'b0}}, 1'b1});
                        end else begin
                            done_next = 1'b0;
                        end
                        state_next = fcfpt_pkg::ST_EMIT;
                    end else begin
                        // start request: load start plus one half, kick off lanes
                        for (int i = 0; i < NCH; i++) begin
                            acc_next[i] = {start_val[i], fcfpt_pkg::HALF_ONE};
                        end
                        rem_next       = n_eff;
                        div_next       = n_eff;
                        done_next      = 1'b0;
                        lane_ctrl.load = 1'b1;
                        cnt_next       = '0;
                        state_next     = fcfpt_pkg::ST_DIV;
                    end
                end
            end
            fcfpt_pkg::ST_DIV: begin
                lane_ctrl.shift = 1'b1;
                cnt_next        = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                if (cnt_reg == CNT_LAST) begin
                    state_next = fcfpt_pkg::ST_FIX;
                end
            end
            fcfpt_pkg::ST_FIX: begin
                // quotients complete, signs applied in the lanes
                for (int i = 0; i < NCH; i++) begin
                    inc_next[i] = lane_step[i];
                end
                state_next = fcfpt_pkg::ST_EMIT;
            end
            fcfpt_pkg::ST_EMIT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {rem_reg,
                                   acc_reg[fcfpt_pkg::CH_DIST][AH:FB],
                                   acc_reg[fcfpt_pkg::CH_PITCH][AH:FB],
                                   acc_reg[fcfpt_pkg::CH_ANGLE][AH:FB],
                                   acc_reg[fcfpt_pkg::CH_Y][AH:FB],
                                   acc_reg[fcfpt_pkg::CH_X][AH:FB]};
                    mlast_next  = done_reg;
                    state_next  = fcfpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fcfpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= fcfpt_pkg::ST_IDLE;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            done_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                acc_reg[i] <= '0;
                inc_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            done_reg   <= done_next;
            mvalid_reg <= mvalid_next;
            for (int i = 0; i < NCH; i++) begin
                acc_reg[i] <= acc_next[i];
                inc_reg[i] <= inc_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        div_reg   <= div_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

    // a start request always begins a fresh division pass
    a_start_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_axis_tuser == fcfpt_pkg::CMD_START) |=>
        (state_reg == fcfpt_pkg::ST_DIV && cnt_reg == '0))
        else $error("start request did not enter division");

    // steps are taken only after all quotient bits are in
    a_fix_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fcfpt_pkg::ST_FIX) |->
        ($past(state_reg) == fcfpt_pkg::ST_DIV && $past(cnt_reg) == CNT_LAST))
        else $error("step fix without full division");

    // last marks a tween that just reached zero ticks
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[fcfpt_pkg::OUT_W-1 -: DW] == '0))
        else $error("last flagged with ticks left");

    // a tick never raises the remaining count
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_axis_tuser == fcfpt_pkg::CMD_TICK) |=> (rem_reg <= $past(rem_reg)))
        else $error("tick raised remaining count");

endmodule
